// File: hw/rtl/bn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch normalization package
// Shared types and constants for the batch normalization block.
// ----------------------------------------------------------------------------
package bn_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;
	localparam int QDEPTH   = 4;

	typedef struct packed {
		logic               is_load;
		logic [CH_W-1:0]    channel;
		logic signed [15:0] sample;
		logic signed [15:0] mean_value;
		logic [23:0]        variance;
		logic signed [15:0] gain;
		logic signed [15:0] shift;
	} item_t;

	typedef struct packed {
		logic               en;
		logic [CH_W-1:0]    addr;
		logic signed [31:0] factor;
		logic signed [31:0] offset;
	} tbl_wr_t;

	typedef enum logic [2:0] {
		FOLD_IDLE,
		FOLD_SQRT,
		FOLD_PREP,
		FOLD_DIV,
		FOLD_SAT,
		FOLD_MUL,
		FOLD_OFS
	} fold_state_t;

endpackage

// File: hw/rtl/bn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch normalization front queue
// Accepts input beats and holds them in a short queue.
// ----------------------------------------------------------------------------
module bn_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bn_pkg::item_t             in_item,
	output logic                      head_valid,
	output bn_pkg::item_t             head_item,
	input  logic                      pop
);
	import bn_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	item_t         slot_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   count_q;
	logic          push;

	assign in_stall   = (count_q == (PW+1)'(QDEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// File: hw/rtl/bn_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch normalization parameter fold
// Turns one channel's statistics into a Q16.16 factor and offset.
// ----------------------------------------------------------------------------
module bn_fold (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bn_pkg::item_t   item,
	input  logic [23:0]     epsilon,
	output logic            busy,
	output bn_pkg::tbl_wr_t wr
);
	import bn_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	fold_state_t        state_q, state_d;
	logic [41:0]        sh_q;
	logic [23:0]        rem_q;
	logic [20:0]        root_q;
	logic [5:0]         cnt_q;
	logic [CH_W-1:0]    ch_q;
	logic               wr_ok_q;
	logic signed [15:0] mean_q;
	logic signed [15:0] gain_q;
	logic signed [15:0] bias_q;
	logic signed [31:0] f_q;
	logic signed [47:0] prod_q;

	logic [23:0]        sq_rem;
	logic [23:0]        sq_trial;
	logic               sq_take;
	logic [22:0]        dv_rem;
	logic               dv_take;
	logic [15:0]        mag;
	logic [40:0]        qs;
	logic signed [47:0] ofs_full;

	assign sq_rem   = {rem_q[21:0], sh_q[41:40]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_take  = (sq_rem >= sq_trial);
	assign dv_rem   = {rem_q[21:0], sh_q[39]};
	assign dv_take  = (dv_rem >= {2'b00, root_q});
	assign mag      = gain_q[15] ? 16'(-gain_q) : 16'(gain_q);
	assign qs       = gain_q[15] ? -{1'b0, sh_q[39:0]} : {1'b0, sh_q[39:0]};
	// Offset = shift * 256 - floor((mean * F + 128) / 256).
	assign ofs_full = 48'(bias_q) * 48'sd256 - ((prod_q + 48'sd128) >>> 8);

	assign busy     = (state_q != FOLD_IDLE);
	assign wr.en     = (state_q == FOLD_OFS) && wr_ok_q;
	assign wr.addr   = ch_q;
	assign wr.factor = f_q;
	assign wr.offset = sat32(ofs_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FOLD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FOLD_IDLE: if (start) state_d = FOLD_SQRT;
			FOLD_SQRT: if (cnt_q == '0) state_d = FOLD_PREP;
			FOLD_PREP: state_d = (root_q == '0) ? FOLD_MUL : FOLD_DIV;
			FOLD_DIV:  if (cnt_q == '0) state_d = FOLD_SAT;
			FOLD_SAT:  state_d = FOLD_MUL;
			FOLD_MUL:  state_d = FOLD_OFS;
			FOLD_OFS:  state_d = FOLD_IDLE;
			default:   state_d = FOLD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FOLD_IDLE: begin
				if (start) begin
					sh_q    <= {1'b0, 25'(item.variance) + 25'(epsilon), 16'h0};
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= 6'd20;
					ch_q    <= item.channel;
					wr_ok_q <= (32'(item.channel) < CHANNELS);
					mean_q  <= item.mean_value;
					gain_q  <= item.gain;
					bias_q  <= item.shift;
				end
			end
			FOLD_SQRT: begin
				sh_q  <= {sh_q[39:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
				if (sq_take) begin
					rem_q  <= sq_rem - sq_trial;
					root_q <= {root_q[19:0], 1'b1};
				end else begin
					rem_q  <= sq_rem;
					root_q <= {root_q[19:0], 1'b0};
				end
			end
			FOLD_PREP: begin
				// Numerator |gain| * 2^24 plus half the root for rounding.
				sh_q  <= {2'b00, {mag, 24'h0} + 40'(root_q[20:1])};
				rem_q <= '0;
				cnt_q <= 6'd39;
				f_q   <= '0;
			end
			FOLD_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				sh_q  <= {2'b00, sh_q[38:0], dv_take};
				if (dv_take) begin
					rem_q <= 24'(dv_rem - {2'b00, root_q});
				end else begin
					rem_q <= 24'(dv_rem);
				end
			end
			FOLD_SAT: begin
				f_q <= sat32(48'(signed'(qs)));
			end
			FOLD_MUL: begin
				prod_q <= 48'(mean_q) * 48'(f_q);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/bn_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch normalization execute pipeline
// Holds the folded tables and applies factor * x + offset per data beat.
// ----------------------------------------------------------------------------
module bn_exec (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bn_pkg::tbl_wr_t           wr,
	input  logic                      issue,
	input  logic [bn_pkg::CH_W-1:0]   issue_channel,
	input  logic signed [15:0]        issue_sample,
	output logic                      pipe_en,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [15:0]        result_value,
	output logic [bn_pkg::CH_W-1:0]   result_channel,
	output logic                      saturated
);
	import bn_pkg::*;

	logic [63:0]        table_mem [CHANNELS];
	logic [63:0]        rd_s1;
	logic               valid_s1, valid_s2, valid_q;
	logic               inr_s1;
	logic [CH_W-1:0]    ch_s1, ch_s2;
	logic signed [15:0] x_s1;
	logic signed [47:0] prod_s2;
	logic signed [31:0] ofs_s2;
	logic signed [31:0] f_rd, o_rd;
	logic signed [48:0] sum;
	logic signed [32:0] y;

	assign pipe_en = !(valid_q && out_stall);
	assign out_valid = valid_q;

	assign f_rd = inr_s1 ? rd_s1[63:32] : 32'sd0;
	assign o_rd = inr_s1 ? rd_s1[31:0]  : 32'sd0;
	assign sum  = 49'(prod_s2) + (49'(ofs_s2) <<< 8) + 49'sd32768;
	assign y    = 33'(sum >>> 16);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			table_mem[wr.addr] <= {wr.factor, wr.offset};
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= table_mem[issue_channel];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			inr_s1  <= (32'(issue_channel) < CHANNELS);
			ch_s1   <= issue_channel;
			x_s1    <= issue_sample;
			prod_s2 <= 48'(f_rd) * 48'(x_s1);
			ofs_s2  <= o_rd;
			ch_s2   <= ch_s1;
			result_channel <= ch_s2;
			if (y > 33'sd32767) begin
				result_value <= 16'sh7fff;
				saturated    <= 1'b1;
			end else if (y < -33'sd32768) begin
				result_value <= 16'sh8000;
				saturated    <= 1'b1;
			end else begin
				result_value <= y[15:0];
				saturated    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

endmodule

// File: hw/rtl/batch_norm_inference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch normalization for inference
// Per-channel y = factor * x + offset with folded parameters.
// ----------------------------------------------------------------------------
// Usage: beats enter on in_valid / in_stall. A load beat (mode 0) folds one
// channel's mean, variance, gain and shift into a Q16.16 factor and offset
// and writes them to the channel tables; it yields no result. A data beat
// (mode 1) yields one result beat on out_valid / out_stall with the Q8.8
// value, its channel and a clip flag.
// Data beats sustain one per cycle through the three stage multiply-add
// pipeline while no load is being folded and out_stall does not hold the
// pipeline. A load beat occupies the fold unit through a digit-by-digit
// square root, a bit-serial division, a saturation step, then a multiply
// and an offset step. Beats queued behind a load wait in a four entry
// queue, so that loads and data stay in order.
// Reset clears the queue, the pipeline valids and sets epsilon to one; the
// tables hold nothing meaningful until a channel is loaded. When out_stall
// is high while a result waits, the pipeline holds, the queue fills and
// in_stall rises once four beats are waiting. The user must write epsilon
// by cfg_wr_en only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module batch_norm_inference (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    mode,
	input  logic [5:0]              channel,
	input  logic signed [15:0]      sample,
	input  logic signed [15:0]      mean_value,
	input  logic [23:0]             variance,
	input  logic signed [15:0]      gain,
	input  logic signed [15:0]      shift,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [15:0]      result_value,
	output logic [5:0]              result_channel,
	output logic                    saturated,
	input  logic                    cfg_wr_en,
	input  logic [23:0]             cfg_wr_data
);
	import bn_pkg::*;

	item_t   in_item, head_item;
	tbl_wr_t tbl_wr;
	logic    head_valid;
	logic    fold_busy;
	logic    pipe_en;
	logic    pop;
	logic    load_start;
	logic    data_issue;
	logic [23:0] eps_q;

	assign in_item.is_load    = (mode == 1'b0);
	assign in_item.channel    = channel;
	assign in_item.sample     = sample;
	assign in_item.mean_value = mean_value;
	assign in_item.variance   = variance;
	assign in_item.gain       = gain;
	assign in_item.shift      = shift;

	// A beat leaves the queue only when the fold unit is free, so that a
	// data beat always reads tables that every earlier load has written.
	assign pop        = head_valid && !fold_busy && (head_item.is_load || pipe_en);
	assign load_start = pop && head_item.is_load;
	assign data_issue = pop && !head_item.is_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 24'd1;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	bn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	bn_fold u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (load_start),
		.item    (head_item),
		.epsilon (eps_q),
		.busy    (fold_busy),
		.wr      (tbl_wr)
	);

	bn_exec u_exec (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (tbl_wr),
		.issue          (data_issue),
		.issue_channel  (head_item.channel),
		.issue_sample   (head_item.sample),
		.pipe_en        (pipe_en),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.result_channel (result_channel),
		.saturated      (saturated)
	);

endmodule
